/* rtl/core/s2dasc_pkg.sv */
package s2dasc_pkg;

  localparam int unsigned MAG_W      = 32;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [3:0]       digit_t;
  typedef logic [6:0]       char_t;
  typedef logic [IDX_W-1:0] idx_t;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SH for every 32-bit x
  localparam mag_t        RECIP10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SH = 35;

  localparam char_t ASCII_ZERO  = 7'd48;
  localparam char_t ASCII_MINUS = 7'd45;

endpackage

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// Channel  | Dir | Ports                               | Beat
// ---------+-----+-------------------------------------+------------------------------
// in       | in  | in_valid, in_ready, in_value[31:0]  | one signed integer
// out      | out | out_valid, out_ready,               | one ASCII character,
//          |     | out_char_code[6:0], out_last        | out_last on the final one
//
// Steps: the item is accepted in idle, then the divide loop makes one pass of the
//   shared 32x32 reciprocal multiplier per digit, then one character goes out per
//   cycle while out_ready holds, with '-' ahead of the digits when negative.
// in_ready is high only between items; the next item may enter while the final
//   character still waits in the output register.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// A stall on out_ready freezes the character sequencer.
module signed_int_to_decimal_ascii_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output s2dasc_pkg::char_t     out_char_code,
  output logic                  out_last
);
  import s2dasc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  mag_t       mag_r, mag_nxt;
  idx_t       nd_r, nd_nxt;        // write index in divide loop
  idx_t       idx_r, idx_nxt;      // read index while emitting, MSD first
  logic       sign_pend_r, sign_pend_nxt;
  digit_t     digit_r [MAX_DIGITS];
  logic       out_valid_r, out_valid_nxt;
  char_t      out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic                 in_acc;
  logic                 load_en;
  logic [2*MAG_W-1:0]   prod;
  mag_t                 quot;
  mag_t                 rem_full;
  digit_t               rem;
  mag_t                 in_mag;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_en   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign in_mag    = in_value[MAG_W-1] ? (MAG_W'(0) - mag_t'(in_value)) : mag_t'(in_value);

  // shared divide-by-ten unit
  assign prod      = mag_r * RECIP10;
  assign quot      = MAG_W'(prod >> RECIP10_SH);
  assign rem_full  = mag_r - (quot << 3) - (quot << 1);
  assign rem       = rem_full[3:0];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mag_nxt       = in_mag;
          sign_pend_nxt = in_value[MAG_W-1];
          nd_nxt        = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        mag_nxt = quot;
        nd_nxt  = nd_r + idx_t'(1);
        if (quot == '0 || nd_r == idx_t'(MAX_DIGITS - 1)) begin
          idx_nxt   = nd_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_en) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ASCII_ZERO + char_t'(digit_r[idx_r]);
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - idx_t'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    nd_r       <= nd_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == ST_DIV) begin
      digit_r[nd_r] <= rem;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // remainder of the shared unit is always a decimal digit
  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem <= digit_t'(9)))
    else $error("divide unit remainder out of range");

  // negative input always gets its minus sign queued
  a_sign_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_value[MAG_W-1]) |=> sign_pend_r)
    else $error("minus sign not queued");

  // sign goes out before any digit and never ends the text
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en && sign_pend_r) |=> (out_valid && out_char_code == ASCII_MINUS && !out_last))
    else $error("minus sign not emitted first");

  // final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_char_code != ASCII_MINUS))
    else $error("text ends on minus sign");

  // no new item while the digit store is still being written or read
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_DIV) |-> !in_ready)
    else $error("input accepted mid-item");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import s2dasc_pkg::*;

  // Longest run of cycles with no beat on either channel before we call it a hang.
  // The worst correct case is a ten-digit divide loop plus long random gaps on the
  // sender and long stalls on the receiver, which stays well under this.
  localparam int unsigned HANG_LIMIT   = 2000;
  // Quiet cycles after the last expected character; long enough for one full item.
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 21;

  // One character of a number's decimal text.
  typedef struct packed {
    char_t code;
    logic  last;
  } text_char_t;

  bit                 clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  char_t              out_char_code;
  logic               out_last;

  // Characters still owed by the block, oldest first.
  text_char_t  pending_text[$];

  // Idle and stall odds, in percent, set per test.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned values_sent   = 0;
  int unsigned chars_checked = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  signed_int_to_decimal_ascii_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decimal text of a two's complement value: '-' for negatives, then digits
  // most significant first with no leading zeros. The magnitude is unsigned, so
  // the most negative value still comes out right.
  function automatic void predict_text(logic [31:0] value);
    logic [31:0] mag;
    digit_t      digits [MAX_DIGITS];
    int          n;
    int          i;
    n   = 0;
    mag = value[31] ? (32'd0 - value) : value;
    do begin
      digits[n] = digit_t'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < MAX_DIGITS);
    if (value[31]) begin
      pending_text.push_back('{ASCII_MINUS, 1'b0});
    end
    for (i = n - 1; i >= 0; i--) begin
      pending_text.push_back('{char_t'(ASCII_ZERO + digits[i]), (i == 0)});
    end
  endfunction

  // Mostly values with a chosen digit count and sign so every length shows up
  // often; a quarter are raw 32-bit patterns so every input bit toggles.
  function automatic logic [31:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int unsigned     ndig;
    bit              neg;
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    ndig = $urandom_range(10, 1);
    neg  = 1'($urandom_range(1));
    lo   = 1;
    repeat (ndig - 1) lo *= 10;
    hi   = lo * 10 - 1;
    if (ndig == 1) begin
      lo = 0;
    end
    if (hi > 64'd2147483647) begin
      hi = neg ? 64'd2147483648 : 64'd2147483647;
    end
    mag = lo + ($urandom % (hi - lo + 1));
    return neg ? 32'(64'd0 - mag) : 32'(mag);
  endfunction

  // Present one value at a falling edge, after a random number of idle cycles,
  // and hold it until the block takes it. Valid stays high across back-to-back
  // beats; only one assignment per falling edge.
  task automatic send_value(logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_text(value);
    values_sent++;
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every accepted character is compared against the oldest owed one.
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (pending_text.size() == 0) begin
        $display("%0t: extra char: got code=%0d last=%0b, expected nothing",
                 $time, out_char_code, out_last);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (out_char_code !== want.code) begin
          $display("%0t: char_code mismatch: expected %0d, got %0d",
                   $time, want.code, out_char_code);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Hang detector: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d chars still owed",
                 $time, quiet_cycles, pending_text.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Zero, one, minus one, both ends of the range and the value next to the most
  // negative one, plus an alternating bit pattern.
  task automatic test_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h8000_0001);
    send_value(32'hAAAA_AAAA);
  endtask

  // Every digit count, at the edges where one more digit appears: 10^k and
  // 10^k - 1, signs alternating so both text lengths with and without '-' show.
  task automatic test_digit_lengths();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    for (k = 1; k <= 9; k++) begin
      p = p * 10;
      send_value((k % 2) ? p : (32'd0 - p));
      send_value((k % 2) ? (32'd0 - (p - 1)) : (p - 1));
    end
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_random_streaming();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_random_sender_idle();
    sender_idle_pct    = 65;
    receiver_stall_pct = 0;
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_random_receiver_stall();
    sender_idle_pct    = 0;
    receiver_stall_pct = 65;
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct    = 25;
    receiver_stall_pct = 25;
    run_random(RANDOM_ITEMS);
  endtask

  initial begin
    // Synchronous reset: held low while the clock runs, released mid-cycle.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_digit_lengths();
    test_random_streaming();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then leave room for any stray character.
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (range ends, every digit count, random values),",
             values_sent);
    $display("checked %0d characters under streaming, idle and stall phases; %0d errors",
             chars_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/s2dasc_pkg.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
verif/tb_top.sv
